@@ hw/rtl/drkp_pkg.sv @@
// package for the der rsa key parser: step modes, status codes, der tags,
// the element order table and the record passed from parser to output stage
// no dependencies
`timescale 1ns / 1ps

package drkp_pkg;

   localparam int MAX_LEN_BYTES_DEF = 4;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int STEP_W = 4;

   typedef enum logic [2:0] {
      MODE_DONE = 3'd0,
      MODE_HDR  = 3'd1,
      MODE_SKIP = 3'd2,
      MODE_EMIT = 3'd3,
      MODE_PAD  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_BAD_TAG = 3'd1,
      STATUS_BAD_LEN = 3'd2,
      STATUS_TRUNC   = 3'd3,
      STATUS_SHORT   = 3'd4
   } status_type;

   localparam logic [7:0] TAG_SEQUENCE     = 8'h30;
   localparam logic [7:0] TAG_BIT_STRING   = 8'h03;
   localparam logic [7:0] TAG_INTEGER      = 8'h02;
   localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
   localparam logic [7:0] PAD_BYTE         = 8'h00;

   localparam logic [7:0] MIN_BYTES_PUBLIC  = 8'd64;
   localparam logic [7:0] MIN_BYTES_PRIVATE = 8'd128;
   localparam logic [7:0] BYTE_TOTAL_CAP    = 8'd128;

   localparam logic FMT_PUBLIC  = 1'b0;
   localparam logic FMT_PRIVATE = 1'b1;

   typedef struct packed {
      logic [7:0] tag;
      mode_type   mode;
      logic [2:0] fid;
   } step_type;

   // one record per accepted beat that yields a content byte, a status, or both
   typedef struct packed {
      logic       has_data;
      logic [2:0] fid;
      logic [7:0] data;
      logic       keep;
      logic       flast;
      logic       has_status;
      status_type status;
   } rec_type;

   function automatic step_type step_lookup(input logic fmt, input logic [STEP_W-1:0] step);
      step_type s;
      s = '{tag: PAD_BYTE, mode: MODE_DONE, fid: 3'd0};
      if (fmt == FMT_PUBLIC) begin
         unique case (step) inside
            4'd0:    s = '{tag: TAG_SEQUENCE,   mode: MODE_HDR,  fid: 3'd0};
            4'd1:    s = '{tag: TAG_SEQUENCE,   mode: MODE_SKIP, fid: 3'd0};
            4'd2:    s = '{tag: TAG_BIT_STRING, mode: MODE_HDR,  fid: 3'd0};
            4'd3:    s = '{tag: PAD_BYTE,       mode: MODE_PAD,  fid: 3'd0};
            4'd4:    s = '{tag: TAG_SEQUENCE,   mode: MODE_HDR,  fid: 3'd0};
            4'd5:    s = '{tag: TAG_INTEGER,    mode: MODE_EMIT, fid: 3'd0};
            4'd6:    s = '{tag: TAG_INTEGER,    mode: MODE_EMIT, fid: 3'd1};
            default: s = '{tag: PAD_BYTE,       mode: MODE_DONE, fid: 3'd0};
         endcase
      end else begin
         unique case (step) inside
            4'd0:          s = '{tag: TAG_SEQUENCE,     mode: MODE_HDR,  fid: 3'd0};
            4'd1:          s = '{tag: TAG_INTEGER,      mode: MODE_SKIP, fid: 3'd0};
            4'd2:          s = '{tag: TAG_SEQUENCE,     mode: MODE_SKIP, fid: 3'd0};
            4'd3:          s = '{tag: TAG_OCTET_STRING, mode: MODE_HDR,  fid: 3'd0};
            4'd4:          s = '{tag: TAG_SEQUENCE,     mode: MODE_HDR,  fid: 3'd0};
            4'd5:          s = '{tag: TAG_INTEGER,      mode: MODE_SKIP, fid: 3'd0};
            [4'd6:4'd13]:  s = '{tag: TAG_INTEGER,      mode: MODE_EMIT,
                                 fid: 3'(step - 4'd6)};
            default:       s = '{tag: PAD_BYTE,         mode: MODE_DONE, fid: 3'd0};
         endcase
      end
      return s;
   endfunction

endpackage

@@ hw/rtl/drkp_front.sv @@
// parser front end: takes key bytes, walks the der element order and builds
// one output record per beat that yields results; holds the format register
// depends on drkp_pkg
`timescale 1ns / 1ps

module drkp_front import drkp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_byte,
   input  logic       req_end_of_key,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_key_format,
   input  logic       q_full,
   output logic       q_push,
   output rec_type    q_rec
);

   localparam int LenW = 8 * MAX_LENGTH_BYTES;
   localparam int CntW = $clog2(MAX_LENGTH_BYTES + 1);
   localparam logic [6:0] MaxLen = 7'(MAX_LENGTH_BYTES);

   logic              fmt_ff;
   logic              stage_ff, stage_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LenW-1:0]   acc_ff, acc_in;
   logic [CntW-1:0]   lbl_ff, lbl_in;
   logic [LenW-1:0]   cl_ff, cl_in;
   logic              first_ff, first_in;
   logic [2:0]        idx_ff, idx_in;
   logic [7:0]        total_ff, total_in;
   status_type        err_ff, err_in;
   logic              done_ff, done_in;

   step_type          cur, nxt;
   logic [STEP_W:0]   step_plus;
   logic              adv_done;
   logic [LenW-1:0]   acc_shift;
   logic [LenW-1:0]   len_val;
   logic [6:0]        n_len;
   logic              len_hit;
   logic              adv;
   logic              emit;
   logic              accept;
   logic [7:0]        min_total;
   status_type        status;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign cur       = step_lookup(fmt_ff, step_ff);
   assign step_plus = {1'b0, step_ff} + (STEP_W+1)'(1);
   assign nxt       = step_lookup(fmt_ff, step_plus[STEP_W-1:0]);
   assign adv_done  = step_plus[STEP_W] || (nxt.mode == MODE_DONE);
   assign acc_shift = LenW'({acc_ff, req_key_byte});
   assign n_len     = req_key_byte[6:0];

   always_comb begin
      stage_in = stage_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      lbl_in   = lbl_ff;
      cl_in    = cl_ff;
      first_in = first_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      done_in  = done_ff;
      emit     = 1'b0;
      adv      = 1'b0;
      len_hit  = 1'b0;
      len_val  = acc_shift;
      total_in = (total_ff < BYTE_TOTAL_CAP) ? total_ff + 8'd1 : total_ff;

      if (err_ff != STATUS_OK || done_ff) begin
         // nothing more until the end beat
      end else if (cur.mode == MODE_DONE) begin
         done_in = 1'b1;
      end else if (!stage_ff) begin
         if (req_key_byte != cur.tag) begin
            err_in = STATUS_BAD_TAG;
         end else if (cur.mode == MODE_PAD) begin
            adv = 1'b1;
         end else begin
            if (cur.mode == MODE_EMIT) begin
               idx_in = cur.fid;
            end
            stage_in = 1'b1;
         end
      end else if (lbl_ff != '0) begin
         acc_in = acc_shift;
         lbl_in = lbl_ff - CntW'(1);
         if (lbl_ff == CntW'(1)) begin
            len_hit = 1'b1;
            len_val = acc_shift;
         end
      end else if (cl_ff != '0) begin
         emit     = (cur.mode == MODE_EMIT);
         first_in = 1'b0;
         cl_in    = cl_ff - LenW'(1);
         if (cl_ff == LenW'(1)) begin
            adv = 1'b1;
         end
      end else if (req_key_byte[7]) begin
         // long form, 0x80 is the indefinite form
         if (n_len == 7'd0 || n_len > MaxLen) begin
            err_in = STATUS_BAD_LEN;
         end else begin
            acc_in = '0;
            lbl_in = CntW'(n_len);
         end
      end else begin
         len_hit = 1'b1;
         len_val = LenW'(n_len);
      end

      if (len_hit) begin
         if (cur.mode == MODE_HDR) begin
            adv = 1'b1;
         end else begin
            cl_in    = len_val;
            first_in = 1'b1;
            if (len_val == '0) begin
               adv = 1'b1;
            end
         end
      end

      if (adv) begin
         acc_in   = '0;
         lbl_in   = '0;
         cl_in    = '0;
         first_in = 1'b0;
         stage_in = 1'b0;
         if (adv_done) begin
            done_in = 1'b1;
            step_in = '1;
         end else begin
            step_in = step_plus[STEP_W-1:0];
         end
      end

      min_total = (fmt_ff == FMT_PRIVATE) ? MIN_BYTES_PRIVATE : MIN_BYTES_PUBLIC;
      if (total_in < min_total) begin
         status = STATUS_SHORT;
      end else if (err_in != STATUS_OK) begin
         status = err_in;
      end else if (!done_in) begin
         status = STATUS_TRUNC;
      end else begin
         status = STATUS_OK;
      end

      // end beat puts the stream back to its start
      if (req_end_of_key) begin
         stage_in = 1'b0;
         step_in  = '0;
         acc_in   = '0;
         lbl_in   = '0;
         cl_in    = '0;
         first_in = 1'b0;
         idx_in   = 3'd0;
         total_in = 8'd0;
         err_in   = STATUS_OK;
         done_in  = 1'b0;
      end
   end

   assign q_push           = accept && (emit || req_end_of_key);
   assign q_rec.has_data   = emit;
   assign q_rec.fid        = idx_ff;
   assign q_rec.data       = req_key_byte;
   assign q_rec.keep       = !(first_ff && req_key_byte == PAD_BYTE);
   assign q_rec.flast      = (cl_ff == LenW'(1));
   assign q_rec.has_status = req_end_of_key;
   assign q_rec.status     = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_PUBLIC;
      end else if (csr_valid) begin
         fmt_ff <= csr_key_format;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         step_ff  <= '0;
         lbl_ff   <= '0;
         first_ff <= 1'b0;
         idx_ff   <= 3'd0;
         total_ff <= 8'd0;
         err_ff   <= STATUS_OK;
         done_ff  <= 1'b0;
      end else if (accept) begin
         stage_ff <= stage_in;
         step_ff  <= step_in;
         lbl_ff   <= lbl_in;
         first_ff <= first_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
         err_ff   <= err_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cl_ff  <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
         cl_ff  <= cl_in;
      end
   end

endmodule

@@ hw/rtl/drkp_queue.sv @@
// short record queue between the parser front end and the output stage
// depends on drkp_pkg
`timescale 1ns / 1ps

module drkp_queue import drkp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output rec_type head
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   rec_type         entries_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

@@ hw/rtl/drkp_back.sv @@
// output stage: drains records from the queue into the result register,
// a record with both a content byte and a status goes out as two beats
// depends on drkp_pkg
`timescale 1ns / 1ps

module drkp_back import drkp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  rec_type    head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [2:0] rsp_field_id,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_keep_byte,
   output logic       rsp_field_last,
   output logic [2:0] rsp_status_code,
   output logic       rsp_stream_last
);

   logic       valid_ff, valid_in;
   logic       sent_ff, sent_in;
   logic       kind_ff, kind_in;
   logic [2:0] fid_ff, fid_in;
   logic [7:0] data_ff, data_in;
   logic       keep_ff, keep_in;
   logic       flast_ff, flast_in;
   logic [2:0] status_ff, status_in;
   logic       slast_ff, slast_in;
   logic       load;
   logic       send_data;

   assign load      = !q_empty && (!valid_ff || rsp_ready);
   assign send_data = head.has_data && !sent_ff;
   // hold the record while its status beat is still to come
   assign q_pop     = load && !(send_data && head.has_status);

   always_comb begin
      valid_in  = valid_ff;
      sent_in   = sent_ff;
      kind_in   = kind_ff;
      fid_in    = fid_ff;
      data_in   = data_ff;
      keep_in   = keep_ff;
      flast_in  = flast_ff;
      status_in = status_ff;
      slast_in  = slast_ff;
      if (load) begin
         valid_in = 1'b1;
         sent_in  = send_data && head.has_status;
         if (send_data) begin
            kind_in   = 1'b0;
            fid_in    = head.fid;
            data_in   = head.data;
            keep_in   = head.keep;
            flast_in  = head.flast;
            status_in = STATUS_OK;
            slast_in  = 1'b0;
         end else begin
            kind_in   = 1'b1;
            fid_in    = 3'd0;
            data_in   = 8'd0;
            keep_in   = 1'b0;
            flast_in  = 1'b0;
            status_in = head.status;
            slast_in  = 1'b1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      fid_ff    <= fid_in;
      data_ff   <= data_in;
      keep_ff   <= keep_in;
      flast_ff  <= flast_in;
      status_ff <= status_in;
      slast_ff  <= slast_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_field_id    = fid_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_keep_byte   = keep_ff;
   assign rsp_field_last  = flast_ff;
   assign rsp_status_code = status_ff;
   assign rsp_stream_last = slast_ff;

endmodule

@@ hw/rtl/der_rsa_key_parser_core.sv @@
// channel  | direction | beat carries
// req_     | in        | key_byte, end_of_key
// rsp_     | out       | result_kind, field_id, data_byte, keep_byte, field_last,
//          |           | status_code, stream_last
// csr_     | in        | key_format (always ready)
//
// one key byte a cycle while the queue is not full: the parser state updates once per beat
// results pass through a record queue and the result register; an end beat
// that also closes an integer takes two output beats, so the output stage
// sets the rate there
// req_ready drops only when the queue is full; synchronous reset, no clearing pass
`timescale 1ns / 1ps

module der_rsa_key_parser_core import drkp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF,
   parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_byte,
   input  logic       req_end_of_key,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [2:0] rsp_field_id,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_keep_byte,
   output logic       rsp_field_last,
   output logic [2:0] rsp_status_code,
   output logic       rsp_stream_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_key_format
);

   rec_type push_rec;
   rec_type head;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   drkp_front #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_byte   (req_key_byte),
      .req_end_of_key (req_end_of_key),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_key_format (csr_key_format),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_rec          (push_rec)
   );

   drkp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   drkp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_field_id    (rsp_field_id),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_keep_byte   (rsp_keep_byte),
      .rsp_field_last  (rsp_field_last),
      .rsp_status_code (rsp_status_code),
      .rsp_stream_last (rsp_stream_last)
   );

endmodule

@@ hw/rtl/drkp_checker.sv @@
// port checks for the der rsa key parser result channel, bound to the top level
// depends on drkp_pkg and der_rsa_key_parser_core
`timescale 1ns / 1ps

module drkp_checker import drkp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [2:0] rsp_field_id,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_keep_byte,
   input logic       rsp_field_last,
   input logic [2:0] rsp_status_code,
   input logic       rsp_stream_last
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_data_byte) && $stable(rsp_status_code)
         && $stable(rsp_field_id) && $stable(rsp_stream_last))
      else $error("result beat changed while stalled");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> !rsp_stream_last
         && rsp_status_code == STATUS_OK)
      else $error("content beat carries status");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_stream_last && rsp_field_id == 3'd0
         && rsp_data_byte == 8'd0 && !rsp_keep_byte && !rsp_field_last)
      else $error("status beat carries content");

   // a stripped byte is always zero (the front end strips only a leading zero)
   a_strip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind && !rsp_keep_byte |-> rsp_data_byte == 8'd0)
      else $error("stripped byte is not zero");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_status_code <= STATUS_SHORT)
      else $error("status code out of range");

endmodule

bind der_rsa_key_parser_core drkp_checker u_drkp_checker (.*);

@@ tb/sv/tb_der_rsa_key_parser_core.sv @@
// self-checking testbench for der_rsa_key_parser_core: der key streams in, field bytes
// and end-of-key status out, checked against a cycle-free parser model kept in the bench
// depends on drkp_pkg and der_rsa_key_parser_core
`timescale 1ns / 1ps

module tb_der_rsa_key_parser_core;
   import drkp_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 1050;

   typedef struct packed {
      logic       kind;
      logic [2:0] fid;
      logic [7:0] data;
      logic       keep;
      logic       flast;
      logic [2:0] status;
      logic       slast;
   } parse_beat_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } key_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_key_byte = 8'h00;
   logic       req_end_of_key = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic [2:0] rsp_field_id;
   logic [7:0] rsp_data_byte;
   logic       rsp_keep_byte;
   logic       rsp_field_last;
   logic [2:0] rsp_status_code;
   logic       rsp_stream_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_key_format = 1'b0;

   der_rsa_key_parser_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_byte   (req_key_byte),
      .req_end_of_key (req_end_of_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_field_id   (rsp_field_id),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_keep_byte  (rsp_keep_byte),
      .rsp_field_last (rsp_field_last),
      .rsp_status_code(rsp_status_code),
      .rsp_stream_last(rsp_stream_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_key_format (csr_key_format)
   );

   always #5 clock = ~clock;

   // parser model state
   logic        fmt_model;
   logic [3:0]  step_now;
   logic        tag_taken;
   logic [31:0] len_accum;
   logic [2:0]  len_left;
   logic [31:0] body_left;
   logic        body_first;
   logic [2:0]  field_now;
   logic [7:0]  bytes_seen;
   status_type  fault_now;
   logic        parse_done;

   parse_beat_type parse_beats_due[$];
   key_beat_type   bytes_to_send[$];
   key_beat_type   phase_beats[$];
   key_beat_type   carry[$];
   logic [7:0]     key_build[$];

   int len_fault = -1;
   bit pad_fault = 1'b0;
   int fail_count = 0;
   int send_gap = 0;
   bit send_calm = 1'b0;
   int hold_gap = 0;
   bit hold_calm = 1'b0;
   int stuck_cycles = 0;

   function automatic void der_step(input logic fmt, input logic [3:0] step,
                                    output logic [7:0] tag, output mode_type mode,
                                    output logic [2:0] fid);
      tag  = PAD_BYTE;
      mode = MODE_DONE;
      fid  = 3'd0;
      if (fmt == FMT_PUBLIC) begin
         case (step)
            4'd0, 4'd4: begin tag = TAG_SEQUENCE; mode = MODE_HDR; end
            4'd1: begin tag = TAG_SEQUENCE; mode = MODE_SKIP; end
            4'd2: begin tag = TAG_BIT_STRING; mode = MODE_HDR; end
            4'd3: begin tag = PAD_BYTE; mode = MODE_PAD; end
            4'd5, 4'd6: begin
               tag  = TAG_INTEGER;
               mode = MODE_EMIT;
               fid  = 3'(step - 4'd5);
            end
            default: ;
         endcase
      end else begin
         case (step)
            4'd0, 4'd4: begin tag = TAG_SEQUENCE; mode = MODE_HDR; end
            4'd1, 4'd5: begin tag = TAG_INTEGER; mode = MODE_SKIP; end
            4'd2: begin tag = TAG_SEQUENCE; mode = MODE_SKIP; end
            4'd3: begin tag = TAG_OCTET_STRING; mode = MODE_HDR; end
            default: begin
               if (step >= 4'd6 && step <= 4'd13) begin
                  tag  = TAG_INTEGER;
                  mode = MODE_EMIT;
                  fid  = 3'(step - 4'd6);
               end
            end
         endcase
      end
   endfunction

   task automatic clear_key_state();
      step_now   = 4'd0;
      tag_taken  = 1'b0;
      len_accum  = '0;
      len_left   = '0;
      body_left  = '0;
      body_first = 1'b0;
      field_now  = 3'd0;
      bytes_seen = 8'd0;
      fault_now  = STATUS_OK;
      parse_done = 1'b0;
   endtask

   task automatic next_element();
      logic [4:0] nxt;
      logic [7:0] t;
      mode_type   m;
      logic [2:0] f;
      nxt        = {1'b0, step_now} + 5'd1;
      len_accum  = '0;
      len_left   = '0;
      body_left  = '0;
      body_first = 1'b0;
      tag_taken  = 1'b0;
      if (nxt <= 5'd15) der_step(fmt_model, nxt[3:0], t, m, f);
      else m = MODE_DONE;
      if (m == MODE_DONE) begin
         parse_done = 1'b1;
         nxt = 5'd15;
      end
      step_now = nxt[3:0];
   endtask

   task automatic length_done(input mode_type m, input logic [31:0] len);
      if (m == MODE_HDR) begin
         next_element();
      end else begin
         body_left  = len;
         body_first = 1'b1;
         if (len == 0) next_element();
      end
   endtask

   task automatic parse_der_byte(input logic [7:0] b, input logic eok);
      logic [7:0]     t;
      mode_type       m;
      logic [2:0]     f;
      logic [7:0]     floor_bytes;
      parse_beat_type beat;
      if (bytes_seen < BYTE_TOTAL_CAP) bytes_seen++;
      der_step(fmt_model, step_now, t, m, f);
      if (fault_now == STATUS_OK && !parse_done) begin
         if (m == MODE_DONE) begin
            parse_done = 1'b1;
         end else if (!tag_taken) begin
            if (b != t) fault_now = STATUS_BAD_TAG;
            else if (m == MODE_PAD) next_element();
            else begin
               if (m == MODE_EMIT) field_now = f;
               tag_taken = 1'b1;
            end
         end else if (len_left != 0) begin
            len_accum = {len_accum[23:0], b};
            len_left--;
            if (len_left == 0) length_done(m, len_accum);
         end else if (body_left != 0) begin
            if (m == MODE_EMIT) begin
               beat       = '0;
               beat.fid   = field_now;
               beat.data  = b;
               beat.keep  = !(body_first && b == 8'h00);
               beat.flast = (body_left == 1);
               parse_beats_due.push_back(beat);
            end
            body_first = 1'b0;
            body_left--;
            if (body_left == 0) next_element();
         end else if (b[7]) begin
            if (b[6:0] == 7'd0 || b[6:0] > MAX_LEN_BYTES_DEF) begin
               fault_now = STATUS_BAD_LEN;
            end else begin
               len_accum = '0;
               len_left  = b[2:0];
            end
         end else begin
            length_done(m, {24'd0, b});
         end
      end
      if (eok) begin
         floor_bytes = (fmt_model == FMT_PRIVATE) ? MIN_BYTES_PRIVATE : MIN_BYTES_PUBLIC;
         beat       = '0;
         beat.kind  = 1'b1;
         beat.slast = 1'b1;
         // too short wins over any recorded error
         if (bytes_seen < floor_bytes) beat.status = STATUS_SHORT;
         else if (fault_now != STATUS_OK) beat.status = fault_now;
         else if (!parse_done) beat.status = STATUS_TRUNC;
         else beat.status = STATUS_OK;
         parse_beats_due.push_back(beat);
         clear_key_state();
      end
   endtask

   // stimulus construction
   task automatic put_len(input logic [31:0] len);
      int n;
      if (len_fault == 0) begin
         len_fault = -1;
         key_build.push_back($urandom_range(0, 1) ? 8'h80 : 8'h85 + 8'($urandom_range(0, 122)));
         return;
      end
      if (len_fault > 0) len_fault--;
      if (len < 128 && $urandom_range(0, 2) != 0) begin
         key_build.push_back(len[7:0]);
      end else begin
         n = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
         n = $urandom_range(n, MAX_LEN_BYTES_DEF);
         key_build.push_back(8'h80 | 8'(n));
         for (int i = n - 1; i >= 0; i--) key_build.push_back(len[8*i +: 8]);
      end
   endtask

   task automatic put_header(input logic [7:0] tag);
      key_build.push_back(tag);
      put_len(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300));
   endtask

   task automatic put_element(input logic [7:0] tag, input int len);
      key_build.push_back(tag);
      put_len(len);
      for (int i = 0; i < len; i++)
         key_build.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom));
   endtask

   function automatic int int_len();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 5);
   endfunction

   task automatic build_key(input logic fmt);
      key_build.delete();
      put_header(TAG_SEQUENCE);
      if (fmt == FMT_PUBLIC) begin
         put_element(TAG_SEQUENCE, $urandom_range(0, 15));
         put_header(TAG_BIT_STRING);
         key_build.push_back(pad_fault ? 8'($urandom_range(1, 255)) : PAD_BYTE);
         put_header(TAG_SEQUENCE);
         put_element(TAG_INTEGER, $urandom_range(0, 1) ? $urandom_range(40, 90) : int_len());
         put_element(TAG_INTEGER, int_len());
      end else begin
         put_element(TAG_INTEGER, $urandom_range(0, 2));
         put_element(TAG_SEQUENCE, $urandom_range(0, 15));
         put_header(TAG_OCTET_STRING);
         put_header(TAG_SEQUENCE);
         put_element(TAG_INTEGER, $urandom_range(0, 2));
         repeat (8) put_element(TAG_INTEGER, int_len());
      end
      // bytes past the last integer are ignored by the parser
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 40)) key_build.push_back(8'($urandom));
   endtask

   task automatic make_key(input logic fmt);
      int kind;
      kind      = $urandom_range(0, 11);
      len_fault = (kind == 6) ? $urandom_range(0, 10) : -1;
      pad_fault = (kind == 7);
      if (kind == 8) begin
         key_build.delete();
         repeat ($urandom_range(1, 16)) key_build.push_back(8'($urandom));
      end else begin
         build_key(fmt);
      end
      if (kind == 9) key_build = key_build[0:$urandom_range(0, key_build.size() - 1)];
      if (kind == 10) key_build[$urandom_range(0, key_build.size() - 1)] = 8'($urandom);
      len_fault = -1;
      pad_fault = 1'b0;
   endtask

   task automatic stage_key();
      foreach (key_build[i])
         phase_beats.push_back('{value: key_build[i], last: (i == key_build.size() - 1)});
   endtask

   task automatic release_phase();
      foreach (phase_beats[i]) bytes_to_send.push_back(phase_beats[i]);
      phase_beats.delete();
   endtask

   // idle means nothing queued, nothing on the wire and nothing owed, over an unbroken calm run
   task automatic wait_idle();
      int calm_cycles;
      calm_cycles = 0;
      while (calm_cycles < DRAIN_CYCLES) begin
         @(posedge clock);
         if (bytes_to_send.size() == 0 && !req_valid && parse_beats_due.size() == 0)
            calm_cycles++;
         else
            calm_cycles = 0;
      end
   endtask

   task automatic write_key_format(input logic fmt);
      csr_valid      <= 1'b1;
      csr_key_format <= fmt;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      fmt_model = fmt;
      csr_valid <= 1'b0;
   endtask

   function automatic string beat_text(input parse_beat_type b);
      return $sformatf("kind %0d fid %0d data %02h keep %0d flast %0d status %0d slast %0d",
                       b.kind, b.fid, b.data, b.keep, b.flast, b.status, b.slast);
   endfunction

   // request driver
   always @(posedge clock) begin
      key_beat_type nxt_beat;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) parse_der_byte(req_key_byte, req_end_of_key);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               nxt_beat = bytes_to_send.pop_front();
               req_key_byte   <= nxt_beat.value;
               req_end_of_key <= nxt_beat.last;
               req_valid      <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
               send_gap = send_calm ? 0 : $urandom_range(0, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      parse_beat_type got;
      parse_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_result_kind, rsp_field_id, rsp_data_byte, rsp_keep_byte,
                   rsp_field_last, rsp_status_code, rsp_stream_last};
            if (parse_beats_due.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing outstanding, expected none, got %s",
                        $time, beat_text(got));
            end else begin
               want = parse_beats_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: result mismatch, expected %s, got %s",
                           $time, beat_text(want), beat_text(got));
               end
            end
            if ($urandom_range(0, 39) == 0) hold_calm = !hold_calm;
            hold_gap = hold_calm ? 0 : $urandom_range(0, 11);
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles == IDLE_LIMIT) begin
            $display("[der_rsa_key_parser_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int  random_sent;
      logic phase_fmt;
      fmt_model = FMT_PUBLIC;
      clear_key_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_key_format(FMT_PUBLIC);

      // long length form of all ones, empty integer, stripped zero, end on last content byte
      key_build = '{8'h30, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h30, 8'h00, 8'h03, 8'h00,
                    8'h00, 8'h30, 8'h00, 8'h02, 8'h00, 8'h02, 8'h02, 8'h00, 8'h80};
      stage_key();
      // indefinite length
      key_build = '{8'h30, 8'h80};
      stage_key();
      // too many length bytes
      key_build = '{8'h30, 8'h85};
      stage_key();
      // wrong outer tag on a one-beat key
      key_build = '{8'hFF};
      stage_key();
      // end while length bytes are still due
      key_build = '{8'h30, 8'h81};
      stage_key();
      release_phase();

      random_sent = 0;
      phase_fmt   = FMT_PRIVATE;
      while (random_sent < RANDOM_BYTES) begin
         wait_idle();
         write_key_format(phase_fmt);
         // a tail held back from the last phase finishes under the new format
         foreach (carry[i]) phase_beats.push_back(carry[i]);
         carry.delete();
         repeat ($urandom_range(1, 4)) begin
            make_key(($urandom_range(0, 7) == 0) ? !phase_fmt : phase_fmt);
            random_sent += key_build.size();
            stage_key();
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 20))
               if (phase_beats.size() > 1) carry.push_front(phase_beats.pop_back());
         release_phase();
         phase_fmt = 1'($urandom_range(0, 1));
      end
      wait_idle();
      write_key_format(phase_fmt);
      foreach (carry[i]) bytes_to_send.push_back(carry[i]);
      carry.delete();
      wait_idle();

      if (fail_count == 0)
         $display("[der_rsa_key_parser_core] OK");
      else
         $display("[der_rsa_key_parser_core] ERROR");
      $finish;
   end

endmodule
